### rtl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;

  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
  localparam int MAG_W = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_GCD_INIT,
    ST_GCD_STEP,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic comb;
    logic gcd_init;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic div_sel;
    logic div_swap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic zero;
    logic gcd_done;
    logic div_last;
  } stat_t;

endpackage

### rtl/rau_if.sv
// valid/ready channel interfaces for operands and results
`timescale 1ns / 1ps
interface rau_in_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [1:0]   opcode;
  logic [W-1:0] a_num;
  logic [W-1:0] a_den;
  logic [W-1:0] b_num;
  logic [W-1:0] b_den;
  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [32:0] res_num;
  logic [30:0] res_den;
  logic        div_error;
  modport source (output valid, res_num, res_den, div_error, input ready);
  modport sink (input valid, res_num, res_den, div_error, output ready);
endinterface

### rtl/rau_ctrl.sv
// sequencer for the rational arithmetic unit
`timescale 1ns / 1ps
module rau_ctrl
  import rau_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   out_full;
  logic   den_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
      den_pass <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
      if (cmd.div_init) den_pass <= 1'b0;
      else if (state == ST_DIV_NEXT) den_pass <= 1'b1;
    end
  end

  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_MUL;
      ST_MUL:      state_next = ST_COMB;
      ST_COMB:     state_next = (stat.err || stat.zero) ? ST_DONE : ST_GCD_INIT;
      ST_GCD_INIT: state_next = ST_GCD_STEP;
      ST_GCD_STEP: if (stat.gcd_done) state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV_STEP;
      ST_DIV_STEP: if (stat.div_last) state_next = den_pass ? ST_DONE : ST_DIV_NEXT;
      ST_DIV_NEXT: state_next = ST_DIV_STEP;
      ST_DONE:     if (!out_full || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:      cmd.mul = 1'b1;
      ST_COMB:     cmd.comb = 1'b1;
      ST_GCD_INIT: cmd.gcd_init = 1'b1;
      ST_GCD_STEP: cmd.gcd_step = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = den_pass;
      end
      ST_DIV_NEXT: begin
        cmd.div_swap = 1'b1;
        cmd.div_sel  = 1'b1;
      end
      ST_DONE:     cmd.out_load = !out_full || out_ready;
      default:     cmd = '0;
    endcase
  end

endmodule

### rtl/rau_dp.sv
// operand registers, cross products, gcd and restoring divider
`timescale 1ns / 1ps
module rau_dp
  import rau_pkg::*;
#(
  parameter int W = 16
) (
  input  logic              clk,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [1:0]        opcode,
  input  logic [W-1:0]      a_num,
  input  logic [W-1:0]      a_den,
  input  logic [W-1:0]      b_num,
  input  logic [W-1:0]      b_den,
  output logic [NUM_W-1:0]  res_num,
  output logic [DEN_W-1:0]  res_den,
  output logic              div_error
);

  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int MW = SW;
  localparam int CW = $clog2(MW + 1);

  op_t                 op;
  logic signed [W-1:0] an, ad, bn, bd;
  logic signed [PW-1:0] p0, p1, p2;
  logic                 err;
  logic                 zero;
  logic                 neg;
  logic [MW-1:0]        mag, den;
  logic [MW-1:0]        gx, gy;
  logic [CW-1:0]        gk;
  logic [MW-1:0]        dq, dr, dd;
  logic [CW-1:0]        cnt;
  logic [MW-1:0]        rmag, rden;
  logic                 gcd_busy;

  logic signed [SW-1:0] num_c, den_c, num_f, den_f;
  logic [MW:0]          trial;
  logic [MW:0]          rsh;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= op_t'(opcode);
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
      err <= (a_den == '0) || (b_den == '0) || ((op_t'(opcode) == OP_DIV) && (b_num == '0));
    end
    if (cmd.mul) begin
      case (op)
        OP_MUL: begin
          p0 <= an * bn;
          p1 <= '0;
          p2 <= ad * bd;
        end
        OP_DIV: begin
          p0 <= an * bd;
          p1 <= '0;
          p2 <= ad * bn;
        end
        default: begin
          p0 <= an * bd;
          p1 <= bn * ad;
          p2 <= ad * bd;
        end
      endcase
    end
  end

  always_comb begin
    if (op == OP_SUB) num_c = SW'(p0) - SW'(p1);
    else num_c = SW'(p0) + SW'(p1);
    den_c = SW'(p2);
    if (den_c < 0) begin
      num_f = -num_c;
      den_f = -den_c;
    end else begin
      num_f = num_c;
      den_f = den_c;
    end
  end

  // binary gcd: pull out common twos, halve an even side, else subtract odd from odd
  assign gcd_busy = (gx != gy);

  always_ff @(posedge clk) begin
    if (cmd.comb) begin
      zero <= (num_c == '0);
      neg  <= num_f < 0;
      mag  <= (num_f < 0) ? MW'(-num_f) : MW'(num_f);
      den  <= MW'(den_f);
    end
    if (cmd.gcd_init) begin
      gx <= mag;
      gy <= den;
      gk <= '0;
    end else if (cmd.gcd_step && gcd_busy) begin
      if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gk <= gk + 1'b1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx > gy) begin
        gx <= gx - gy;
      end else begin
        gy <= gy - gx;
      end
    end
  end

  assign rsh   = {dr, dq[MW-1]};
  assign trial = rsh - {1'b0, dd};

  // restoring divider, one quotient bit per cycle, numerator then denominator
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dd   <= gx << gk;
      dq   <= mag;
      dr   <= '0;
      cnt  <= CW'(MW - 1);
    end else if (cmd.div_swap) begin
      rmag <= dq;
      dq   <= den;
      dr   <= '0;
      cnt  <= CW'(MW - 1);
    end else if (cmd.div_step) begin
      if (!trial[MW]) begin
        dr <= trial[MW-1:0];
        dq <= {dq[MW-2:0], 1'b1};
      end else begin
        dr <= rsh[MW-1:0];
        dq <= {dq[MW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cmd.div_sel && cnt == '0)
        rden <= {dq[MW-2:0], !trial[MW]};
    end
  end

  assign stat.err      = err;
  assign stat.zero     = (num_c == '0);
  assign stat.gcd_done = !gcd_busy;
  assign stat.div_last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (err) begin
        res_num   <= '0;
        res_den   <= '0;
        div_error <= 1'b1;
      end else if (zero) begin
        res_num   <= '0;
        res_den   <= DEN_W'(1);
        div_error <= 1'b0;
      end else begin
        res_num   <= neg ? NUM_W'(-rmag) : NUM_W'(rmag);
        res_den   <= DEN_W'(rden);
        div_error <= 1'b0;
      end
    end
  end

endmodule

### rtl/rational_arithmetic_unit_core.sv
// rational arithmetic unit: add/sub/mul/div of fractions reduced to lowest terms
// binary gcd: one shift or subtract per cycle
// divider: one quotient bit per cycle, numerator then denominator
// throughput: one item at a time; next input transfer the cycle after the result is registered
// reset: synchronous active-high rst returns the sequencer to idle and clears output valid
`timescale 1ns / 1ps
module rational_arithmetic_unit_core
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rau_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .stat     (stat),
    .opcode   (in_ch.opcode),
    .a_num    (in_ch.a_num),
    .a_den    (in_ch.a_den),
    .b_num    (in_ch.b_num),
    .b_den    (in_ch.b_den),
    .res_num  (out_ch.res_num),
    .res_den  (out_ch.res_den),
    .div_error(out_ch.div_error)
  );

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |-> !cmd.out_load)
    else $error("input transfer during result load");

  a_err_den_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.div_error) |-> (out_ch.res_den == '0))
    else $error("error result with nonzero denominator");

  a_ok_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.div_error) |-> (out_ch.res_den != '0))
    else $error("valid result with zero denominator");

endmodule

### verif/rau_tb_if.sv
// testbench item types: operand sets and expected fractions
`timescale 1ns / 1ps
package rau_tb_types;
  import rau_pkg::*;

  typedef struct {
    op_t               op;
    logic signed [15:0] an;
    logic signed [15:0] ad;
    logic signed [15:0] bn;
    logic signed [15:0] bd;
    bit                hold_for_drain;
  } operand_set_t;

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             err;
  } fraction_t;
endpackage

### verif/tb.sv
// testbench for the rational arithmetic unit: fraction ops checked against a local reducer
`timescale 1ns / 1ps
module tb;
  import rau_pkg::*;
  import rau_tb_types::*;

  localparam int TOTAL_RANDOM = 1600;
  localparam int QUIET_TAIL = 150;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rau_in_if #(.W(16)) in_ch();
  rau_out_if out_ch();

  rational_arithmetic_unit_core #(.OPERAND_WIDTH(16)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  operand_set_t pending_ops[$];
  fraction_t    reduced_q[$];
  int           fail_count = 0;
  int           sent_count = 0;
  int           total_items = 0;
  bit           quiet = 1'b0;
  int           send_gap = 0;
  int           recv_gap = 0;
  int           stall_cycles = 0;

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t reduce_fraction(operand_set_t s);
    fraction_t r;
    longint an, ad, bn, bd, num, den;
    longint unsigned mag, g;
    an = s.an;
    ad = s.ad;
    bn = s.bn;
    bd = s.bd;
    if (ad == 0 || bd == 0 || (s.op == OP_DIV && bn == 0)) begin
      r.num = '0;
      r.den = '0;
      r.err = 1'b1;
      return r;
    end
    case (s.op)
      OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      OP_MUL: begin num = an * bn; den = ad * bd; end
      default: begin num = an * bd; den = ad * bn; end
    endcase
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    r.err = 1'b0;
    if (num == 0) begin
      r.num = '0;
      r.den = DEN_W'(1);
      return r;
    end
    mag = (num < 0) ? -num : num;
    g = euclid_gcd(mag, den);
    mag = mag / g;
    r.num = (num < 0) ? NUM_W'(-mag) : NUM_W'(mag);
    r.den = DEN_W'(den / g);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("bad %s: got %0d, want %0d (item %0d)", what, got, want, sent_count);
    fail_count++;
  endtask

  task automatic add_op(op_t op, int an, int ad, int bn, int bd, bit hold = 1'b0);
    operand_set_t s;
    s.op = op;
    s.an = 16'(an);
    s.ad = 16'(ad);
    s.bn = 16'(bn);
    s.bd = 16'(bd);
    s.hold_for_drain = hold;
    pending_ops.push_back(s);
  endtask

  // full range or small magnitudes; small ones share factors more often
  function automatic int pick_operand(bit tiny);
    if (tiny)
      return $urandom_range(0, 15) == 0 ? 0 : int'($urandom_range(0, 128)) - 64;
    return $urandom_range(0, 40) == 0 ? 0 : int'($signed($urandom_range(0, 65535) - 32768));
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= '0;
      in_ch.a_num <= '0;
      in_ch.a_den <= '0;
      in_ch.b_num <= '0;
      in_ch.b_den <= '0;
    end else begin
      operand_set_t s;
      logic nv;
      if (in_ch.valid && in_ch.ready) begin
        s.op = op_t'(in_ch.opcode);
        s.an = in_ch.a_num;
        s.ad = in_ch.a_den;
        s.bn = in_ch.b_num;
        s.bd = in_ch.b_den;
        reduced_q.push_back(reduce_fraction(s));
        sent_count++;
        if (sent_count > total_items - QUIET_TAIL) quiet = 1'b1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        nv = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].hold_for_drain &&
                       (reduced_q.size() > 0 || in_ch.valid))) begin
          s = pending_ops.pop_front();
          in_ch.opcode <= s.op;
          in_ch.a_num <= s.an;
          in_ch.a_den <= s.ad;
          in_ch.b_num <= s.bn;
          in_ch.b_den <= s.bd;
          nv = 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 6);
        end
        in_ch.valid <= nv;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      fraction_t want;
      if (out_ch.valid && out_ch.ready) begin
        if (reduced_q.size() == 0) begin
          $display("unexpected result transfer %0d/%0d", $signed(out_ch.res_num),
                   out_ch.res_den);
          fail_count++;
        end else begin
          want = reduced_q.pop_front();
          if (out_ch.res_num !== want.num)
            report("res_num", $signed(out_ch.res_num), $signed(want.num));
          if (out_ch.res_den !== want.den) report("res_den", out_ch.res_den, want.den);
          if (out_ch.div_error !== want.err) report("div_error", out_ch.div_error, want.err);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_ops.size() == 0 && reduced_q.size() == 0))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("rational_arithmetic_unit_core: mismatch");
      $finish;
    end
  end

  initial begin
    bit tiny;
    add_op(OP_ADD, -32768, 32767, -32768, 32767);
    add_op(OP_SUB, 32767, -32768, -32768, 32767);
    add_op(OP_MUL, -32768, -32768, -32768, -32768);
    add_op(OP_DIV, 32767, 32767, -32768, -32767);
    add_op(OP_MUL, -32768, 32767, 32767, -32768);
    add_op(OP_DIV, -32768, -32767, 32767, 32766);
    // large numerator over a unit denominator
    add_op(OP_MUL, -32768, 1, -32768, 1);
    add_op(OP_DIV, -32768, 1, 1, -32768);
    add_op(OP_ADD, 3, 0, 5, 7);
    add_op(OP_SUB, 3, 4, 5, 0);
    add_op(OP_MUL, 0, 0, 0, 0);
    add_op(OP_DIV, 3, 4, 0, 7);
    add_op(OP_DIV, 0, 4, 0, 7);
    add_op(OP_SUB, 5, 6, 10, 12);
    add_op(OP_ADD, 1, 2, -1, 2);
    add_op(OP_MUL, 0, -5, 7, 9);
    add_op(OP_DIV, 0, 5, -7, 9);
    add_op(OP_ADD, 1, -2, 1, -3);
    add_op(OP_DIV, -4, 6, 2, -9);
    add_op(OP_MUL, -6, -4, -8, 3);
    add_op(OP_SUB, 1, 3, 1, 6);
    add_op(OP_ADD, 21845, -21846, -21846, 21845);
    add_op(OP_MUL, 1, 1, 1, 1, 1'b1);
    for (int i = 0; i < TOTAL_RANDOM; i++) begin
      tiny = $urandom_range(0, 2) == 0;
      add_op(op_t'($urandom_range(0, 3)), pick_operand(tiny), pick_operand(tiny),
             pick_operand(tiny), pick_operand(tiny), i == TOTAL_RANDOM / 2);
    end
    total_items = pending_ops.size();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_ops.size() == 0 && sent_count == total_items && reduced_q.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("rational_arithmetic_unit_core: match");
    else
      $display("rational_arithmetic_unit_core: mismatch");
    $finish;
  end
endmodule
